// ===== sv/i2c_master_register_block_read_top_assert.svh =====
// Assertion macros shared by the register block read I2C master RTL.
// No dependencies; take it in with a plain include of the bare file name.
`ifndef I2C_MASTER_REGISTER_BLOCK_READ_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_BLOCK_READ_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under synchronous reset.
`define I2CBR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c block read assertion failed");
// Next-cycle implication under synchronous reset.
`define I2CBR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c block read assertion failed");
`else
`define I2CBR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define I2CBR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/i2cbr_pkg.sv =====
// Package for the register block read I2C master: payload structs, phase codes,
// register indexes and reset values. No dependencies.
package i2cbr_pkg;

   typedef struct packed {
      logic       start_request;
      logic [7:0] byte_count;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] read_byte;
      logic       last_byte;
      logic       done_res;
      logic       no_ack;
   } rsp_type;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_START_A   = 5'd1,
      PH_START_B   = 5'd2,
      PH_START_C   = 5'd3,
      PH_SEND_LOW  = 5'd4,
      PH_SEND_HIGH = 5'd5,
      PH_ACK_LOW   = 5'd6,
      PH_ACK_HIGH  = 5'd7,
      PH_READ_LOW  = 5'd8,
      PH_READ_HIGH = 5'd9,
      PH_MACK_LOW  = 5'd10,
      PH_MACK_HIGH = 5'd11,
      PH_STOP_A    = 5'd12,
      PH_STOP_B    = 5'd13,
      PH_STOP_C    = 5'd14,
      PH_FAIL_A    = 5'd15,
      PH_FAIL_B    = 5'd16,
      PH_FAIL_C    = 5'd17
   } phase_type;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGISTER_ADDRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_TICKS      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT      = 2'd3;

   localparam logic [6:0]  RST_DEVICE_ADDRESS   = 7'd21;
   localparam logic [7:0]  RST_REGISTER_ADDRESS = 8'h00;
   localparam logic [15:0] RST_PHASE_TICKS      = 16'd20;
   localparam logic [15:0] RST_ACK_TIMEOUT      = 16'd250;

endpackage

// ===== sv/i2c_master_register_block_read_top.sv =====
// The response for a request (one bus tick) is registered and appears in the cycle after it is taken.
// Throughput: one request per cycle unless a held response stalls it; the phase sequencer advances once per request.
// Backpressure on rsp_ stalls req_ through the single output register only.
// Reset (synchronous, active high) returns the sequencer to idle, clears the counters
// and loads the default address, pointer, phase length and ack timeout.
// Register block read I2C master top level; depends on i2cbr_pkg and the assert header.
`include "i2c_master_register_block_read_top_assert.svh"

module i2c_master_register_block_read_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  i2cbr_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output i2cbr_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [i2cbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [i2cbr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [6:0]  dev_addr_ff;
   logic [7:0]  reg_addr_ff;
   logic [15:0] phase_ticks_ff;
   logic [15:0] ack_timeout_ff;

   i2cbr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] wait_ff, wait_in;
   logic        rd_part_ff, rd_part_in;

   i2cbr_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic        req_fire;
   logic [15:0] phase_len;
   logic        over;
   logic [15:0] wait_inc;
   logic [7:0]  rx_byte;
   logic        start_take;
   logic        start_shown;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign phase_len = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign over      = ({1'b0, tick_ff} + 17'd1) >= {1'b0, phase_len};
   assign wait_inc  = wait_ff + 16'd1;
   assign rx_byte   = {shift_ff[6:0], req_data.sda_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= i2cbr_pkg::RST_DEVICE_ADDRESS;
         reg_addr_ff    <= i2cbr_pkg::RST_REGISTER_ADDRESS;
         phase_ticks_ff <= i2cbr_pkg::RST_PHASE_TICKS;
         ack_timeout_ff <= i2cbr_pkg::RST_ACK_TIMEOUT;
      end else if (csr_we) begin
         case (csr_index)
            i2cbr_pkg::CSR_DEVICE_ADDRESS:   dev_addr_ff    <= csr_wdata[6:0];
            i2cbr_pkg::CSR_REGISTER_ADDRESS: reg_addr_ff    <= csr_wdata[7:0];
            i2cbr_pkg::CSR_PHASE_TICKS:      phase_ticks_ff <= csr_wdata;
            i2cbr_pkg::CSR_ACK_TIMEOUT:      ack_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state of the bus sequencer.
   always_comb begin
      phase_in   = phase_ff;
      tick_in    = over ? tick_ff : tick_ff + 16'd1;
      bit_in     = bit_ff;
      left_in    = left_ff;
      shift_in   = shift_ff;
      wait_in    = wait_ff;
      rd_part_in = rd_part_ff;
      case (phase_ff)
         i2cbr_pkg::PH_START_A: begin
            if (over) phase_in = i2cbr_pkg::PH_START_B;
         end
         i2cbr_pkg::PH_START_B: begin
            if (over) phase_in = i2cbr_pkg::PH_START_C;
         end
         i2cbr_pkg::PH_START_C: begin
            if (over) begin
               shift_in = {dev_addr_ff, rd_part_ff};
               bit_in   = 4'd0;
               phase_in = i2cbr_pkg::PH_SEND_LOW;
            end
         end
         i2cbr_pkg::PH_SEND_LOW: begin
            if (over) phase_in = i2cbr_pkg::PH_SEND_HIGH;
         end
         i2cbr_pkg::PH_SEND_HIGH: begin
            if (over) begin
               if (bit_ff[2:0] == 3'd7) begin
                  wait_in  = 16'd0;
                  phase_in = i2cbr_pkg::PH_ACK_LOW;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  shift_in = {shift_ff[6:0], 1'b0};
                  phase_in = i2cbr_pkg::PH_SEND_LOW;
               end
            end
         end
         i2cbr_pkg::PH_ACK_LOW: begin
            if (over) phase_in = i2cbr_pkg::PH_ACK_HIGH;
         end
         i2cbr_pkg::PH_ACK_HIGH: begin
            if (over) begin
               if (!req_data.sda_level) begin
                  if (rd_part_ff) begin
                     if (left_ff == 8'd0) begin
                        phase_in = i2cbr_pkg::PH_STOP_A;
                     end else begin
                        bit_in   = 4'd0;
                        shift_in = 8'd0;
                        phase_in = i2cbr_pkg::PH_READ_LOW;
                     end
                  end else if (!bit_ff[3]) begin
                     // address acked: send the register pointer next
                     shift_in = reg_addr_ff;
                     bit_in   = 4'd8;
                     phase_in = i2cbr_pkg::PH_SEND_LOW;
                  end else begin
                     phase_in = i2cbr_pkg::PH_STOP_A;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (wait_inc >= ack_timeout_ff) phase_in = i2cbr_pkg::PH_FAIL_A;
               end
            end
         end
         i2cbr_pkg::PH_READ_LOW: begin
            if (over) phase_in = i2cbr_pkg::PH_READ_HIGH;
         end
         i2cbr_pkg::PH_READ_HIGH: begin
            if (over) begin
               shift_in = rx_byte;
               if (bit_ff >= 4'd7) begin
                  left_in  = left_ff - 8'd1;
                  phase_in = i2cbr_pkg::PH_MACK_LOW;
               end else begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = i2cbr_pkg::PH_READ_LOW;
               end
            end
         end
         i2cbr_pkg::PH_MACK_LOW: begin
            if (over) phase_in = i2cbr_pkg::PH_MACK_HIGH;
         end
         i2cbr_pkg::PH_MACK_HIGH: begin
            if (over) begin
               if (left_ff == 8'd0) begin
                  phase_in = i2cbr_pkg::PH_STOP_A;
               end else begin
                  bit_in   = 4'd0;
                  shift_in = 8'd0;
                  phase_in = i2cbr_pkg::PH_READ_LOW;
               end
            end
         end
         i2cbr_pkg::PH_STOP_A: begin
            if (over) phase_in = i2cbr_pkg::PH_STOP_B;
         end
         i2cbr_pkg::PH_STOP_B: begin
            if (over) phase_in = i2cbr_pkg::PH_STOP_C;
         end
         i2cbr_pkg::PH_STOP_C: begin
            if (over) begin
               if (!rd_part_ff) begin
                  // pointer written: restart for the read part
                  rd_part_in = 1'b1;
                  phase_in   = i2cbr_pkg::PH_START_A;
               end else begin
                  phase_in = i2cbr_pkg::PH_IDLE;
               end
            end
         end
         i2cbr_pkg::PH_FAIL_A: begin
            if (over) phase_in = i2cbr_pkg::PH_FAIL_B;
         end
         i2cbr_pkg::PH_FAIL_B: begin
            if (over) phase_in = i2cbr_pkg::PH_FAIL_C;
         end
         i2cbr_pkg::PH_FAIL_C: begin
            if (over) phase_in = i2cbr_pkg::PH_IDLE;
         end
         default: begin
            phase_in = i2cbr_pkg::PH_IDLE;
            tick_in  = tick_ff;
            if (req_data.start_request) begin
               left_in    = req_data.byte_count;
               rd_part_in = 1'b0;
               bit_in     = 4'd0;
               shift_in   = 8'd0;
               wait_in    = 16'd0;
               phase_in   = i2cbr_pkg::PH_START_A;
            end
         end
      endcase
      // every phase change restarts the phase timer
      if (phase_in != phase_ff) tick_in = 16'd0;
   end

   // Response for the current tick, from the phase held at its start.
   always_comb begin
      rsp_in           = '0;
      rsp_in.scl_drive = 1'b1;
      rsp_in.sda_drive = 1'b1;
      rsp_in.busy_res  = 1'b1;
      case (phase_ff)
         i2cbr_pkg::PH_START_B, i2cbr_pkg::PH_STOP_B, i2cbr_pkg::PH_FAIL_B: begin
            rsp_in.sda_drive = 1'b0;
         end
         i2cbr_pkg::PH_START_C, i2cbr_pkg::PH_STOP_A, i2cbr_pkg::PH_FAIL_A: begin
            rsp_in.scl_drive = 1'b0;
            rsp_in.sda_drive = 1'b0;
         end
         i2cbr_pkg::PH_SEND_LOW: begin
            rsp_in.scl_drive = 1'b0;
            rsp_in.sda_drive = shift_ff[7];
         end
         i2cbr_pkg::PH_SEND_HIGH: begin
            rsp_in.sda_drive = shift_ff[7];
         end
         i2cbr_pkg::PH_ACK_LOW, i2cbr_pkg::PH_READ_LOW: begin
            rsp_in.scl_drive = 1'b0;
         end
         i2cbr_pkg::PH_ACK_HIGH, i2cbr_pkg::PH_START_A: ;
         i2cbr_pkg::PH_READ_HIGH: begin
            if (over && bit_ff >= 4'd7) begin
               rsp_in.byte_valid = 1'b1;
               rsp_in.read_byte  = rx_byte;
               rsp_in.last_byte  = (left_ff == 8'd1);
            end
         end
         i2cbr_pkg::PH_MACK_LOW: begin
            rsp_in.scl_drive = 1'b0;
            rsp_in.sda_drive = (left_ff == 8'd0);
         end
         i2cbr_pkg::PH_MACK_HIGH: begin
            rsp_in.sda_drive = (left_ff == 8'd0);
         end
         i2cbr_pkg::PH_STOP_C: begin
            rsp_in.done_res = over && rd_part_ff;
         end
         i2cbr_pkg::PH_FAIL_C: begin
            rsp_in.done_res = over;
            rsp_in.no_ack   = over;
         end
         default: begin
            rsp_in.busy_res = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= i2cbr_pkg::PH_IDLE;
         tick_ff    <= 16'd0;
         bit_ff     <= 4'd0;
         left_ff    <= 8'd0;
         shift_ff   <= 8'd0;
         wait_ff    <= 16'd0;
         rd_part_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         left_ff    <= left_in;
         shift_ff   <= shift_in;
         wait_ff    <= wait_in;
         rd_part_ff <= rd_part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the response until it is taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign start_take  = req_fire && req_data.start_request && (phase_ff == i2cbr_pkg::PH_IDLE);
   assign start_shown = (phase_ff == i2cbr_pkg::PH_START_A) && rsp_valid && !rsp_data.busy_res;

   `I2CBR_ASSERT_NOW(a_done_busy, clock, reset, rsp_valid && rsp_data.done_res, rsp_data.busy_res)
   `I2CBR_ASSERT_NOW(a_nack_done, clock, reset, rsp_valid && rsp_data.no_ack, rsp_data.done_res)
   `I2CBR_ASSERT_NOW(a_byte_scl, clock, reset, rsp_valid && rsp_data.byte_valid, rsp_data.scl_drive)
   `I2CBR_ASSERT_NOW(a_last_valid, clock, reset, rsp_valid && rsp_data.last_byte, rsp_data.byte_valid)
   `I2CBR_ASSERT_NEXT(a_start_go, clock, reset, start_take, start_shown)

endmodule

// ===== dv/i2cbr_read_checker.sv =====
// Checker for the register block read I2C master: tracks the sequencer per bus tick,
// compares every response field and flags stray responses. Needs i2cbr_pkg.
module i2cbr_read_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  i2cbr_pkg::req_type              req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  i2cbr_pkg::rsp_type              rsp_data,
   input  logic                            csr_we,
   input  logic [i2cbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2cbr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending,
   output logic                            bus_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [6:0]  dev_addr;
   logic [7:0]  reg_ptr;
   logic [15:0] half_len;
   logic [15:0] ack_limit;

   i2cbr_pkg::phase_type phase;
   logic [15:0] ticks;
   logic [3:0]  bit_idx;
   logic [7:0]  remaining;
   logic [7:0]  shreg;
   logic [15:0] high_run;
   logic        read_part;

   i2cbr_pkg::rsp_type sequencer_out_q[$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   // A zero half length behaves as one tick.
   function automatic logic phase_done();
      int unsigned len;
      len = (half_len == 16'd0) ? 32'd1 : 32'(half_len);
      return (32'(ticks) + 32'd1) >= len;
   endfunction

   function automatic logic timed();
      if (phase_done())
         return 1'b1;
      ticks = ticks + 16'd1;
      return 1'b0;
   endfunction

   function automatic void enter(i2cbr_pkg::phase_type nxt);
      phase = nxt;
      ticks = '0;
   endfunction

   // Outputs reflect the phase held at the start of the tick.
   function automatic i2cbr_pkg::rsp_type advance_sequencer(i2cbr_pkg::req_type r);
      i2cbr_pkg::rsp_type o;
      o = '0;
      o.scl_drive = 1'b1;
      o.sda_drive = 1'b1;
      o.busy_res  = 1'b1;
      case (phase)
         i2cbr_pkg::PH_START_A: if (timed()) enter(i2cbr_pkg::PH_START_B);
         i2cbr_pkg::PH_START_B: begin
            o.sda_drive = 1'b0;
            if (timed()) enter(i2cbr_pkg::PH_START_C);
         end
         i2cbr_pkg::PH_START_C: begin
            o.scl_drive = 1'b0;
            o.sda_drive = 1'b0;
            if (timed()) begin
               shreg = {dev_addr, read_part};
               bit_idx = '0;
               enter(i2cbr_pkg::PH_SEND_LOW);
            end
         end
         i2cbr_pkg::PH_SEND_LOW: begin
            o.scl_drive = 1'b0;
            o.sda_drive = shreg[7];
            if (timed()) enter(i2cbr_pkg::PH_SEND_HIGH);
         end
         i2cbr_pkg::PH_SEND_HIGH: begin
            o.sda_drive = shreg[7];
            if (timed()) begin
               if (bit_idx[2:0] == 3'd7) begin
                  high_run = '0;
                  enter(i2cbr_pkg::PH_ACK_LOW);
               end else begin
                  bit_idx = bit_idx + 4'd1;
                  shreg = shreg << 1;
                  enter(i2cbr_pkg::PH_SEND_LOW);
               end
            end
         end
         i2cbr_pkg::PH_ACK_LOW: begin
            o.scl_drive = 1'b0;
            if (timed()) enter(i2cbr_pkg::PH_ACK_HIGH);
         end
         i2cbr_pkg::PH_ACK_HIGH: begin
            // sample every tick once the high half has run out
            if (timed()) begin
               if (!r.sda_level) begin
                  if (read_part) begin
                     if (remaining == 8'd0) begin
                        enter(i2cbr_pkg::PH_STOP_A);
                     end else begin
                        bit_idx = '0;
                        shreg = '0;
                        enter(i2cbr_pkg::PH_READ_LOW);
                     end
                  end else if (bit_idx < 4'd8) begin
                     // bit 3 of the index marks the register pointer byte
                     shreg = reg_ptr;
                     bit_idx = 4'd8;
                     enter(i2cbr_pkg::PH_SEND_LOW);
                  end else begin
                     enter(i2cbr_pkg::PH_STOP_A);
                  end
               end else begin
                  high_run = high_run + 16'd1;
                  if (high_run >= ack_limit) enter(i2cbr_pkg::PH_FAIL_A);
               end
            end
         end
         i2cbr_pkg::PH_READ_LOW: begin
            o.scl_drive = 1'b0;
            if (timed()) enter(i2cbr_pkg::PH_READ_HIGH);
         end
         i2cbr_pkg::PH_READ_HIGH: begin
            if (timed()) begin
               shreg = {shreg[6:0], r.sda_level};
               if (bit_idx >= 4'd7) begin
                  o.byte_valid = 1'b1;
                  o.read_byte  = shreg;
                  o.last_byte  = (remaining == 8'd1);
                  remaining = remaining - 8'd1;
                  enter(i2cbr_pkg::PH_MACK_LOW);
               end else begin
                  bit_idx = bit_idx + 4'd1;
                  enter(i2cbr_pkg::PH_READ_LOW);
               end
            end
         end
         i2cbr_pkg::PH_MACK_LOW: begin
            o.scl_drive = 1'b0;
            o.sda_drive = (remaining == 8'd0);
            if (timed()) enter(i2cbr_pkg::PH_MACK_HIGH);
         end
         i2cbr_pkg::PH_MACK_HIGH: begin
            o.sda_drive = (remaining == 8'd0);
            if (timed()) begin
               if (remaining == 8'd0) begin
                  enter(i2cbr_pkg::PH_STOP_A);
               end else begin
                  bit_idx = '0;
                  shreg = '0;
                  enter(i2cbr_pkg::PH_READ_LOW);
               end
            end
         end
         i2cbr_pkg::PH_STOP_A, i2cbr_pkg::PH_FAIL_A: begin
            o.scl_drive = 1'b0;
            o.sda_drive = 1'b0;
            if (timed())
               enter(phase == i2cbr_pkg::PH_STOP_A ? i2cbr_pkg::PH_STOP_B
                                                   : i2cbr_pkg::PH_FAIL_B);
         end
         i2cbr_pkg::PH_STOP_B, i2cbr_pkg::PH_FAIL_B: begin
            o.sda_drive = 1'b0;
            if (timed())
               enter(phase == i2cbr_pkg::PH_STOP_B ? i2cbr_pkg::PH_STOP_C
                                                   : i2cbr_pkg::PH_FAIL_C);
         end
         i2cbr_pkg::PH_STOP_C: begin
            if (timed()) begin
               if (!read_part) begin
                  read_part = 1'b1;
                  enter(i2cbr_pkg::PH_START_A);
               end else begin
                  o.done_res = 1'b1;
                  enter(i2cbr_pkg::PH_IDLE);
               end
            end
         end
         i2cbr_pkg::PH_FAIL_C: begin
            if (timed()) begin
               o.done_res = 1'b1;
               o.no_ack   = 1'b1;
               enter(i2cbr_pkg::PH_IDLE);
            end
         end
         default: begin
            o.busy_res = 1'b0;
            phase = i2cbr_pkg::PH_IDLE;
            if (r.start_request) begin
               remaining = r.byte_count;
               read_part = 1'b0;
               bit_idx = '0;
               shreg = '0;
               high_run = '0;
               enter(i2cbr_pkg::PH_START_A);
            end
         end
      endcase
      return o;
   endfunction

   function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      i2cbr_pkg::rsp_type want;
      if (reset) begin
         dev_addr  = i2cbr_pkg::RST_DEVICE_ADDRESS;
         reg_ptr   = i2cbr_pkg::RST_REGISTER_ADDRESS;
         half_len  = i2cbr_pkg::RST_PHASE_TICKS;
         ack_limit = i2cbr_pkg::RST_ACK_TIMEOUT;
         phase     = i2cbr_pkg::PH_IDLE;
         ticks     = '0;
         bit_idx   = '0;
         remaining = '0;
         shreg     = '0;
         high_run  = '0;
         read_part = 1'b0;
         sequencer_out_q.delete();
      end else begin
         // retire before taking a new request: a response never answers this edge's tick
         if (rsp_valid && rsp_ready) begin
            if (sequencer_out_q.size() == 0) begin
               $error("response with no request outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               want = sequencer_out_q.pop_front();
               mismatches += field_diff("scl_drive", 8'(want.scl_drive),
                                        8'(rsp_data.scl_drive));
               mismatches += field_diff("sda_drive", 8'(want.sda_drive),
                                        8'(rsp_data.sda_drive));
               mismatches += field_diff("busy_res", 8'(want.busy_res),
                                        8'(rsp_data.busy_res));
               mismatches += field_diff("byte_valid", 8'(want.byte_valid),
                                        8'(rsp_data.byte_valid));
               mismatches += field_diff("read_byte", want.read_byte, rsp_data.read_byte);
               mismatches += field_diff("last_byte", 8'(want.last_byte),
                                        8'(rsp_data.last_byte));
               mismatches += field_diff("done_res", 8'(want.done_res),
                                        8'(rsp_data.done_res));
               mismatches += field_diff("no_ack", 8'(want.no_ack), 8'(rsp_data.no_ack));
            end
         end
         if (req_valid && req_ready)
            sequencer_out_q.push_back(advance_sequencer(req_data));
         if (csr_we) begin
            case (csr_index)
               i2cbr_pkg::CSR_DEVICE_ADDRESS:   dev_addr  = csr_wdata[6:0];
               i2cbr_pkg::CSR_REGISTER_ADDRESS: reg_ptr   = csr_wdata[7:0];
               i2cbr_pkg::CSR_PHASE_TICKS:      half_len  = csr_wdata;
               i2cbr_pkg::CSR_ACK_TIMEOUT:      ack_limit = csr_wdata;
               default: ;
            endcase
         end
      end
      pending  <= sequencer_out_q.size();
      bus_idle <= (phase == i2cbr_pkg::PH_IDLE);
   end

endmodule

// ===== dv/tb.sv =====
// Top of the register block read I2C master testbench: clock, reset, bus tick stimulus,
// register programming and the verdict. Needs i2cbr_pkg, the RTL and i2cbr_read_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   i2cbr_pkg::req_type               req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   i2cbr_pkg::rsp_type               rsp_data;
   logic                             csr_we = 1'b0;
   logic [i2cbr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [i2cbr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int                    fail_count;
   int                    pending;
   logic                  bus_idle;

   int unsigned           idle_pct = 0;
   int unsigned           stall_pct = 0;
   int unsigned           sda_high_pct = 50;

   i2c_master_register_block_read_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2cbr_read_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .bus_idle   (bus_idle)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // One bus tick; returns at the edge that accepts it with valid still high.
   task automatic push_tick(input logic start, input logic [7:0] count);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{start, count, ($urandom_range(99) < sda_high_pct)};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every request has its response.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Clock idle ticks until the sequencer is back in idle, then drain responses.
   task automatic settle();
      do push_tick(1'b0, 8'($urandom)); while (!bus_idle);
      drain();
   endtask

   task automatic run_transfer(input logic [7:0] count, input int unsigned high_pct);
      sda_high_pct = high_pct;
      push_tick(1'b1, count);
      settle();
   endtask

   task automatic write_csr(input logic [i2cbr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Junk above the register width must be dropped.
   task automatic program_regs(input logic [6:0] dev, input logic [7:0] regp,
                               input logic [15:0] half, input logic [15:0] tmo);
      write_csr(i2cbr_pkg::CSR_DEVICE_ADDRESS, {9'($urandom), dev});
      write_csr(i2cbr_pkg::CSR_REGISTER_ADDRESS, {8'($urandom), regp});
      write_csr(i2cbr_pkg::CSR_PHASE_TICKS, half);
      write_csr(i2cbr_pkg::CSR_ACK_TIMEOUT, tmo);
      csr_we <= 1'b0;
   endtask

   initial begin
      int   n;
      logic go;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset, slave always acknowledging; shorten the phases once under way
      sda_high_pct = 0;
      push_tick(1'b1, 8'd1);
      repeat (70) push_tick(1'b0, 8'($urandom));
      drain();
      // zero half length and zero timeout: first high sample at an ack fails
      program_regs(7'd127, 8'hFF, 16'd0, 16'd0);
      settle();
      run_transfer(8'd2, 0);
      run_transfer(8'd3, 100);
      // zero byte count, a short read, then an ack wait that runs out
      program_regs(7'd0, 8'h5A, 16'd1, 16'd40);
      run_transfer(8'd0, 0);
      run_transfer(8'd4, 50);
      run_transfer(8'd1, 100);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         for (int s = 0; s < 3; s++) begin
            // registers change mid-transfer once the responses are drained
            drain();
            program_regs(7'($urandom), 8'($urandom), 16'($urandom_range(3)),
                         $urandom_range(1) ? 16'($urandom_range(12))
                                           : 16'($urandom_range(13, 400)));
            case ($urandom_range(5))
               0: sda_high_pct = 0;
               1: sda_high_pct = 85;
               2: sda_high_pct = 100;
               default: sda_high_pct = 50;
            endcase
            n = $urandom_range(10, 20);
            repeat (n) begin
               // starts landing mid-transfer must be ignored
               go = ($urandom_range(11) == 0);
               if (go && $urandom_range(31) != 0)
                  push_tick(go, 8'($urandom_range(3)));
               else
                  push_tick(go, 8'($urandom));
            end
         end
      end

      // longest half phase: the bus hardly moves in the ticks left
      drain();
      idle_pct = 0;
      stall_pct = 0;
      sda_high_pct = 50;
      program_regs(7'($urandom), 8'($urandom), 16'hFFFF, 16'd250);
      push_tick(1'b1, 8'd2);
      repeat (40) push_tick(1'b0, 8'($urandom));

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #100ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
